// ===== rtl/core/tcrr_pkg.sv =====
// Shared types, constants and helper functions for the text cell refresh renderer.
// No dependencies; imported by every module under rtl/core except tcrr_ram.
`timescale 1ns / 1ps

package tcrr_pkg;

   localparam int DEFAULT_COLS = 8;
   localparam int DEFAULT_ROWS = 4;
   localparam int QUEUE_DEPTH  = 2;

   localparam int OP_W     = 1;
   localparam int COL_W    = 3;
   localparam int ROW_W    = 2;
   localparam int CODE_W   = 16;
   localparam int ATTR_W   = 8;
   localparam int GLYPH_W  = 64;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 7;
   localparam int X_W      = 8;

   localparam int COL_LSB    = 0;
   localparam int ROW_LSB    = COL_LSB + COL_W;
   localparam int CODE_LSB   = ROW_LSB + ROW_W;
   localparam int ATTR_LSB   = CODE_LSB + CODE_W;
   localparam int GLYPH_LSB  = ATTR_LSB + ATTR_W;
   localparam int REQ_BITS   = GLYPH_LSB + GLYPH_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_WRITE      = 1'b0;
   localparam logic [OP_W-1:0] OP_INVALIDATE = 1'b1;

   localparam logic [BYTE_W-1:0]   CMD_PREFIX  = 8'h00;
   localparam logic [BYTE_W-1:0]   DATA_PREFIX = 8'h40;
   localparam logic [BYTE_W-1:0]   PAGE_BASE   = 8'hB0;
   localparam logic [BYTE_W-1:0]   COL_HI_BASE = 8'h10;
   localparam logic [BYTE_W-1:0]   COL_LO_MASK = 8'h0F;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 7'd32;

   localparam int ATTR_INVERT = 0;
   localparam int ATTR_FLIP   = 1;
   localparam int ATTR_MIRROR = 2;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [X_W-1:0]     x;
      logic [2:0]         effects;
      logic [GLYPH_W-1:0] glyph;
   } job_type;

   function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = v[BYTE_W-1-i];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/text_cell_refresh_renderer_top.sv =====
// Top level of the text cell refresh renderer: front end, job queue, serialiser.
// Depends on tcrr_pkg, tcrr_front, tcrr_queue and tcrr_back.
`timescale 1ns / 1ps

// A write transaction to a cell in the grid goes through a shadow RAM read, then a
// compare and update that waits for room in the job queue when the cell changed; an
// invalidate or a cell outside the grid is taken in the idle state. A changed cell
// produces 15 bus bytes, one per cycle from the serialiser's output register while
// rsp_tready is high; unchanged cells overlap with output through a two-entry job
// queue. No clearing pass after reset.
module text_cell_refresh_renderer_top #(
   parameter int COLS = tcrr_pkg::DEFAULT_COLS,
   parameter int ROWS = tcrr_pkg::DEFAULT_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // column[2:0], row[4:3], char_code[20:5], attr[28:21], glyph[92:29], zero pad
   input  logic [tcrr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation
   input  logic                             req_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcrr_pkg::OFFSET_W-1:0]    csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // byte_value
   output logic [tcrr_pkg::BYTE_W-1:0]      rsp_tdata,
   // transfer_start
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   import tcrr_pkg::*;

   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   assign csr_ready = 1'b1;

   tcrr_front #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   tcrr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   tcrr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_start_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || rsp_tuser)
      else $error("byte after end of stream is not a transfer start");

   a_start_is_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == CMD_PREFIX || rsp_tdata == DATA_PREFIX)
      else $error("transfer start on a byte that is not a control prefix");

   a_invalidate_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_INVALIDATE |=> req_tready)
      else $error("front end stalled after an invalidate");

   a_last_not_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser)
      else $error("final byte flagged as transfer start");
`endif

endmodule

// ===== rtl/core/tcrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcrr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/tcrr_front.sv =====
// Front end: accepts cell transactions, checks them against the shadow store
// and queues a render job for each changed cell. Uses tcrr_pkg and tcrr_ram.
`timescale 1ns / 1ps

module tcrr_front #(
   parameter int COLS = tcrr_pkg::DEFAULT_COLS,
   parameter int ROWS = tcrr_pkg::DEFAULT_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tcrr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              csr_valid,
   input  logic [tcrr_pkg::OFFSET_W-1:0]     csr_data,
   output logic                              push_valid,
   input  logic                              push_ready,
   output tcrr_pkg::job_type                 push_job
);

   import tcrr_pkg::*;

   localparam int CELLS = COLS * ROWS;
   localparam int IDX_W = CELLS > 1 ? $clog2(CELLS) : 1;
   localparam int SH_W  = CODE_W + ATTR_W;

   typedef enum logic {ST_IDLE, ST_LOOKUP} state_type;

   state_type             state_ff, state_in;
   logic [CELLS-1:0]      valid_ff, valid_in;
   logic [CELLS-1:0]      written_ff, written_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;

   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [CODE_W-1:0]     code_ff;
   logic [ATTR_W-1:0]     attr_ff;
   logic [GLYPH_W-1:0]    glyph_ff;
   logic [IDX_W-1:0]      idx_ff;

   logic [COL_W-1:0]      req_col;
   logic [ROW_W-1:0]      req_row;
   logic [IDX_W-1:0]      req_idx;
   logic                  in_grid;
   logic                  accept;
   logic                  rd_en;
   logic                  wr_en;
   logic [SH_W-1:0]       rd_data;
   logic [SH_W-1:0]       stored;
   logic                  dirty;

   assign req_col = req_tdata[COL_LSB +: COL_W];
   assign req_row = req_tdata[ROW_LSB +: ROW_W];
   assign in_grid = (int'(req_col) < COLS) && (int'(req_row) < ROWS);
   assign req_idx = IDX_W'(int'(req_row) * COLS + int'(req_col));

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = accept && (req_tuser == OP_WRITE) && in_grid;

   assign stored     = written_ff[idx_ff] ? rd_data : '0;
   assign dirty      = !valid_ff[idx_ff] || (stored != {code_ff, attr_ff});
   assign push_valid = (state_ff == ST_LOOKUP) && dirty;
   assign wr_en      = push_valid && push_ready;

   assign push_job.row     = row_ff;
   assign push_job.x       = X_W'({col_ff, 3'b000}) + X_W'(offset_ff);
   assign push_job.effects = attr_ff[2:0];
   assign push_job.glyph   = glyph_ff;

   tcrr_ram #(
      .WIDTH (SH_W),
      .DEPTH (CELLS)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data ({code_ff, attr_ff}),
      .rd_en   (rd_en),
      .rd_addr (req_idx),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      written_in = written_ff;
      offset_in  = csr_valid ? csr_data : offset_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_INVALIDATE) begin
                  valid_in = '0;
               end else if (in_grid) begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (!dirty) begin
               state_in = ST_IDLE;
            end else if (push_ready) begin
               state_in           = ST_IDLE;
               valid_in[idx_ff]   = 1'b1;
               written_in[idx_ff] = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '1;
         written_ff <= '0;
         offset_ff  <= OFFSET_RESET;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         written_ff <= written_in;
         offset_ff  <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         col_ff   <= req_col;
         row_ff   <= req_row;
         code_ff  <= req_tdata[CODE_LSB +: CODE_W];
         attr_ff  <= req_tdata[ATTR_LSB +: ATTR_W];
         glyph_ff <= req_tdata[GLYPH_LSB +: GLYPH_W];
         idx_ff   <= req_idx;
      end
   end

endmodule

// ===== rtl/core/tcrr_queue.sv =====
// Short job queue between the front end and the byte serialiser.
// Uses tcrr_pkg for the job type.
`timescale 1ns / 1ps

module tcrr_queue #(
   parameter int DEPTH = tcrr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tcrr_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tcrr_pkg::job_type pop_job
);

   import tcrr_pkg::*;

   localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/tcrr_back.sv =====
// Back end: turns one render job into the 15-byte display bus stream.
// Uses tcrr_pkg for the job type, bus constants and byte flip.
`timescale 1ns / 1ps

module tcrr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  tcrr_pkg::job_type             pop_job,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tcrr_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   import tcrr_pkg::*;

   localparam logic [3:0] STEP_CMD_PAGE = 4'd0;
   localparam logic [3:0] STEP_PAGE     = 4'd1;
   localparam logic [3:0] STEP_CMD_LO   = 4'd2;
   localparam logic [3:0] STEP_COL_LO   = 4'd3;
   localparam logic [3:0] STEP_CMD_HI   = 4'd4;
   localparam logic [3:0] STEP_COL_HI   = 4'd5;
   localparam logic [3:0] STEP_DATA     = 4'd6;
   localparam logic [3:0] STEP_GLYPH    = 4'd7;
   localparam logic [3:0] STEP_LAST     = 4'd14;

   logic [3:0]        step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff;
   logic              out_start_ff;
   logic              out_last_ff;

   logic              load;
   logic [2:0]        col_sel;
   logic [2:0]        src;
   logic [BYTE_W-1:0] raw;
   logic [BYTE_W-1:0] shaped;
   logic [BYTE_W-1:0] byte_val;
   logic              byte_start;

   assign load      = pop_valid && (!out_valid_ff || rsp_tready);
   assign pop_ready = load && (step_ff == STEP_LAST);

   assign col_sel = 3'(step_ff - STEP_GLYPH);
   assign src     = pop_job.effects[ATTR_MIRROR] ? ~col_sel : col_sel;
   assign raw     = pop_job.glyph[{src, 3'b000} +: BYTE_W];

   always_comb begin
      shaped = pop_job.effects[ATTR_FLIP] ? flip_byte(raw) : raw;
      if (pop_job.effects[ATTR_INVERT]) begin
         shaped = ~shaped;
      end
      byte_start = 1'b0;
      if (step_ff >= STEP_GLYPH) begin
         byte_val = shaped;
      end else begin
         case (step_ff)
            STEP_CMD_PAGE, STEP_CMD_LO, STEP_CMD_HI: begin
               byte_val   = CMD_PREFIX;
               byte_start = 1'b1;
            end
            STEP_PAGE: begin
               byte_val = PAGE_BASE + BYTE_W'(pop_job.row);
            end
            STEP_COL_LO: begin
               byte_val = COL_LO_MASK & pop_job.x;
            end
            STEP_COL_HI: begin
               byte_val = COL_HI_BASE | (pop_job.x >> 4);
            end
            STEP_DATA: begin
               byte_val   = DATA_PREFIX;
               byte_start = 1'b1;
            end
            default: begin
               byte_val = shaped;
            end
         endcase
      end
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         step_in      = (step_ff == STEP_LAST) ? STEP_CMD_PAGE : step_ff + 1'b1;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_CMD_PAGE;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff  <= byte_val;
         out_start_ff <= byte_start;
         out_last_ff  <= (step_ff == STEP_LAST);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_start_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sim/tcrr_checker.sv =====
// Bus-byte checker for the text cell refresh renderer: watches the request, CSR and
// response channels, renders each accepted cell write itself and compares every byte.
// Depends on tcrr_pkg for field widths, bit positions and bus constants.
`timescale 1ns / 1ps

module tcrr_checker #(
   parameter int COLS = tcrr_pkg::DEFAULT_COLS,
   parameter int ROWS = tcrr_pkg::DEFAULT_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [tcrr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [tcrr_pkg::OFFSET_W-1:0]     csr_data,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [tcrr_pkg::BYTE_W-1:0]       rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast,
   output int                                error_count,
   output int                                pending
);

   import tcrr_pkg::*;

   localparam int CELLS = COLS * ROWS;

   typedef struct {
      logic [BYTE_W-1:0] value;
      logic              start;
      logic              last;
   } bus_byte_type;

   bus_byte_type        bytes_due[$];
   logic [OFFSET_W-1:0] col_offset;
   logic [CODE_W-1:0]   cell_code [CELLS];
   logic [ATTR_W-1:0]   cell_attr [CELLS];
   logic                cell_live [CELLS];

   function automatic void push_byte(input logic [BYTE_W-1:0] value, input logic start,
                                     input logic last);
      bus_byte_type b;
      b.value = value;
      b.start = start;
      b.last  = last;
      bytes_due.push_back(b);
   endfunction

   function automatic void render_cell(input logic [REQ_DATA_W-1:0] data);
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [CODE_W-1:0]  code;
      logic [ATTR_W-1:0]  attr;
      logic [GLYPH_W-1:0] glyph;
      logic [X_W-1:0]     x;
      logic [BYTE_W-1:0]  v;
      logic [BYTE_W-1:0]  r;
      int                 slot;
      int                 src;
      col   = data[COL_LSB +: COL_W];
      row   = data[ROW_LSB +: ROW_W];
      code  = data[CODE_LSB +: CODE_W];
      attr  = data[ATTR_LSB +: ATTR_W];
      glyph = data[GLYPH_LSB +: GLYPH_W];
      if (int'(col) >= COLS || int'(row) >= ROWS) return;
      slot = int'(row) * COLS + int'(col);
      if (cell_live[slot] && cell_code[slot] == code && cell_attr[slot] == attr) return;
      cell_code[slot] = code;
      cell_attr[slot] = attr;
      cell_live[slot] = 1'b1;
      // column address is computed in 8 bits, never exceeds 183 and is sent as is
      x = X_W'({col, 3'b000}) + X_W'(col_offset);
      push_byte(CMD_PREFIX, 1'b1, 1'b0);
      push_byte(PAGE_BASE + BYTE_W'(row), 1'b0, 1'b0);
      push_byte(CMD_PREFIX, 1'b1, 1'b0);
      push_byte(COL_LO_MASK & x, 1'b0, 1'b0);
      push_byte(CMD_PREFIX, 1'b1, 1'b0);
      push_byte(COL_HI_BASE | (x >> 4), 1'b0, 1'b0);
      push_byte(DATA_PREFIX, 1'b1, 1'b0);
      for (int c = 0; c < 8; c++) begin
         src = attr[ATTR_MIRROR] ? 7 - c : c;
         v = glyph[8*src +: 8];
         if (attr[ATTR_FLIP]) begin
            for (int b = 0; b < BYTE_W; b++) r[b] = v[BYTE_W-1-b];
            v = r;
         end
         if (attr[ATTR_INVERT]) v = ~v;
         push_byte(v, 1'b0, c == 7);
      end
   endfunction

   always @(posedge clock) begin
      bus_byte_type want;
      if (reset) begin
         col_offset = OFFSET_RESET;
         for (int i = 0; i < CELLS; i++) begin
            cell_code[i] = '0;
            cell_attr[i] = '0;
            cell_live[i] = 1'b1;
         end
         bytes_due.delete();
         pending     <= 0;
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) col_offset = csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_INVALIDATE) begin
               for (int i = 0; i < CELLS; i++) cell_live[i] = 1'b0;
            end else begin
               render_cell(req_tdata);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               $display("%0t: unexpected byte: expected none, got %02h start %0b last %0b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               error_count <= error_count + 1;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser !== want.start ||
                   rsp_tlast !== want.last) begin
                  $display("%0t: mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                           $time, want.value, want.start, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
                  error_count <= error_count + 1;
               end
            end
         end
         pending <= bytes_due.size();
      end
   end

endmodule

// ===== sim/tb_text_cell_refresh_renderer_top.sv =====
// Testbench top for text_cell_refresh_renderer_top: clock, reset, stimulus and verdict.
// Directed cell writes and invalidates, then random traffic under several idle/stall mixes.
// Depends on tcrr_pkg, the block under test and tcrr_checker.
`timescale 1ns / 1ps

module tb_text_cell_refresh_renderer_top;
   import tcrr_pkg::*;

   localparam int CELLS      = DEFAULT_COLS * DEFAULT_ROWS;
   localparam int SETTLE     = 24;
   localparam int WDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 73;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_WRITE;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [OFFSET_W-1:0]   csr_data = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int error_count;
   int pending;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles = 0;

   logic [CODE_W-1:0] sent_code [CELLS];
   logic [ATTR_W-1:0] sent_attr [CELLS];

   text_cell_refresh_renderer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tcrr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .error_count (error_count),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WDOG_LIMIT) begin
         $display("tb_text_cell_refresh_renderer_top: done, errors");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] cell_word(
      input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
      input logic [CODE_W-1:0] code, input logic [ATTR_W-1:0] attr,
      input logic [GLYPH_W-1:0] glyph);
      logic [REQ_DATA_W-1:0] w;
      w = '0;
      w[COL_LSB +: COL_W]     = col;
      w[ROW_LSB +: ROW_W]     = row;
      w[CODE_LSB +: CODE_W]   = code;
      w[ATTR_LSB +: ATTR_W]   = attr;
      w[GLYPH_LSB +: GLYPH_W] = glyph;
      return w;
   endfunction

   task automatic send_item(input logic op, input logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                             input logic [CODE_W-1:0] code, input logic [ATTR_W-1:0] attr,
                             input logic [GLYPH_W-1:0] glyph);
      sent_code[int'(row) * DEFAULT_COLS + int'(col)] = code;
      sent_attr[int'(row) * DEFAULT_COLS + int'(col)] = attr;
      send_item(OP_WRITE, cell_word(col, row, code, attr, glyph));
   endtask

   task automatic invalidate_all();
      send_item(OP_INVALIDATE, cell_word(COL_W'($urandom), ROW_W'($urandom),
                                         CODE_W'($urandom), ATTR_W'($urandom),
                                         {$urandom, $urandom}));
   endtask

   task automatic wait_empty();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_offset(input logic [OFFSET_W-1:0] value);
      wait_empty();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      int               pick;
      int               slot;
      pick = $urandom_range(99);
      col  = COL_W'($urandom);
      row  = ROW_W'($urandom);
      slot = int'(row) * DEFAULT_COLS + int'(col);
      if (pick < 5) begin
         invalidate_all();
      end else if (pick < 35) begin
         write_cell(col, row, sent_code[slot], sent_attr[slot], {$urandom, $urandom});
      end else begin
         write_cell(col, row, CODE_W'($urandom), ATTR_W'($urandom), {$urandom, $urandom});
      end
   endtask

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         sent_code[i] = '0;
         sent_attr[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset shadow matches code 0 / attr 0, so nothing goes out
      write_cell(3'd0, 2'd0, 16'h0000, 8'h00, 64'h0123_4567_89AB_CDEF);
      write_cell(3'd7, 2'd3, 16'hFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      write_cell(3'd7, 2'd3, 16'hFFFF, 8'hFF, 64'h0);
      write_cell(3'd1, 2'd1, 16'h0041, 8'h00, 64'h0123_4567_89AB_CDEF);
      write_cell(3'd1, 2'd1, 16'h0041, 8'h01, 64'h0123_4567_89AB_CDEF);
      write_cell(3'd1, 2'd1, 16'h0041, 8'h02, 64'h0123_4567_89AB_CDEF);
      write_cell(3'd1, 2'd1, 16'h0041, 8'h04, 64'h0123_4567_89AB_CDEF);
      write_cell(3'd1, 2'd1, 16'h0041, 8'h07, 64'h0123_4567_89AB_CDEF);
      write_cell(3'd1, 2'd1, 16'h0041, 8'h87, 64'h8040_2010_0804_0201);
      write_cell(3'd2, 2'd2, 16'h8000, 8'h00, 64'h0);
      invalidate_all();
      write_cell(3'd0, 2'd0, 16'h0000, 8'h00, 64'hA5A5_5A5A_F00F_0FF0);
      write_cell(3'd1, 2'd1, 16'h0041, 8'h87, 64'h8040_2010_0804_0201);
      write_cell(3'd0, 2'd0, 16'h0000, 8'h00, 64'h0);
      write_cell(3'd5, 2'd3, 16'h1234, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);

      set_offset(7'd127);
      write_cell(3'd7, 2'd0, 16'h0001, 8'h00, 64'h0011_2233_4455_6677);
      write_cell(3'd0, 2'd3, 16'h0002, 8'h04, 64'h0011_2233_4455_6677);
      set_offset(7'd0);
      write_cell(3'd7, 2'd2, 16'h0003, 8'h03, 64'hFEDC_BA98_7654_3210);
      write_cell(3'd0, 2'd0, 16'hFFFF, 8'h00, 64'hFEDC_BA98_7654_3210);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 47; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 47; end
            default: begin send_idle_pct = 28; rsp_stall_pct = 28; end
         endcase
         set_offset(phase == 0 ? 7'd127 : OFFSET_W'($urandom));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == PHASE_ITEMS / 2) wait_empty();
            random_item();
         end
      end

      wait_empty();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_text_cell_refresh_renderer_top: done, clean");
      end else begin
         $display("tb_text_cell_refresh_renderer_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tcrr_pkg.sv
rtl/core/tcrr_ram.sv
rtl/core/tcrr_front.sv
rtl/core/tcrr_queue.sv
rtl/core/tcrr_back.sv
rtl/core/text_cell_refresh_renderer_top.sv
sim/tcrr_checker.sv
sim/tb_text_cell_refresh_renderer_top.sv
